FILE: sv/ssr_pkg.sv
`default_nettype none

package ssr_pkg;

    // Command codes
    localparam logic CMD_VICTIM = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // RRPV and counter constants
    localparam logic [1:0] RRPV_MAX    = 2'd3;
    localparam logic [1:0] RRPV_INSERT = 2'd2;
    localparam logic [1:0] RRPV_HIT    = 2'd0;
    localparam logic [1:0] CTR_MAX     = 2'd3;
    localparam logic [1:0] CTR_MIN     = 2'd0;
    localparam logic [1:0] CTR_INIT    = 2'd2;

    // Signature hash
    localparam int PC_W        = 30;
    localparam int SIG_SHIFT_A = 12;
    localparam int SIG_SHIFT_B = 20;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_EXEC
    } ssr_state_t;

    // Per-item control handed to the row update logic
    typedef struct packed {
        logic cmd;
        logic hit;
        logic set_ok;
        logic way_ok;
    } ssr_item_ctl_t;

    // Write enables and flags returned by the row update logic
    typedef struct packed {
        logic row_we;
        logic ctr_we;
        logic reuse;
    } ssr_upd_ctl_t;

endpackage

`default_nettype wire

FILE: sv/ssr_ifs.sv
`default_nettype none

interface ssr_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [10:0] set_index;
    logic [3:0]  way_index;
    logic [29:0] pc;
    logic        hit;

    modport source (output valid, cmd, set_index, way_index, pc, hit, input ready);
    modport sink   (input valid, cmd, set_index, way_index, pc, hit, output ready);
endinterface

interface ssr_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] victim_way;
    logic       reuse_predicted;

    modport source (output valid, victim_way, reuse_predicted, input ready);
    modport sink   (input valid, victim_way, reuse_predicted, output ready);
endinterface

`default_nettype wire

FILE: sv/ship_srrip_replacement_top.sv
// SRRIP cache replacement with SHiP signature training. A req item carrying
// cmd victim ages the addressed set until its largest RRPV is 3 and answers the
// lowest way at 3; cmd update writes the hit or filled way and trains the PC
// signature counter. Each item returns one rsp item. The signature hash and
// modulo pipeline has three register stages, and the first is loaded at
// acceptance; the signature is ready when the third is loaded. Then the
// synchronous read of the set row and counter memories is presented, and the
// next step modifies, writes back and loads the result register, after which
// the block returns to idle. Items are handled one at a time, so a new item is
// not taken before the last one is written back, and no two accesses to a row
// overlap. A result that waits on rsp.ready holds up the write-back of the
// next item. After reset a clearing pass writes every row to all-3 and every
// counter to 2 over max(NUM_SETS, SIG_ENTRIES) addresses (2048 at the
// defaults); req.ready stays low until it ends. A finished result waits in the
// output register while the next item is accepted.
`default_nettype none

module ship_srrip_replacement_top #(
    parameter int NUM_SETS    = 2048,
    parameter int NUM_WAYS    = 16,
    parameter int SIG_ENTRIES = 1024
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ssr_req_if.sink    req,
    ssr_rsp_if.source  rsp
);

    localparam int SET_AW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int SIG_AW = $clog2(SIG_ENTRIES);
    localparam int ROW_W  = 2 * NUM_WAYS;
    localparam int CLR_N  = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
    localparam int CLR_W  = $clog2(CLR_N);
    localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_N - 1);

    ssr_pkg::ssr_state_t state_reg, state_next;
    logic [CLR_W-1:0]    clr_reg, clr_next;

    // held item fields
    logic        cmd_reg;
    logic [10:0] set_reg;
    logic [3:0]  way_reg;
    logic        hit_reg;

    logic        out_valid_reg;
    logic [3:0]  victim_reg;
    logic        reuse_reg;

    logic        req_ready;
    logic        accept;
    logic        exec_fire;

    logic              sig_valid;
    logic [SIG_AW-1:0] sig;

    logic              rrpv_we, rrpv_re;
    logic [SET_AW-1:0] rrpv_waddr, rrpv_raddr;
    logic [ROW_W-1:0]  rrpv_wdata, rrpv_rdata;
    logic              ctr_we, ctr_re;
    logic [SIG_AW-1:0] ctr_waddr;
    logic [1:0]        ctr_wdata, ctr_rdata;

    logic [31:0]       clr_ext, set_ext;
    logic [SET_AW-1:0] set_addr;

    ssr_pkg::ssr_item_ctl_t item_ctl;
    ssr_pkg::ssr_upd_ctl_t  upd;
    logic [ROW_W-1:0]       new_row;
    logic [1:0]             new_ctr;
    logic [3:0]             victim_way;

    assign req.ready = req_ready;
    assign accept    = req.valid && req_ready;

    assign clr_ext  = 32'(clr_reg);
    assign set_ext  = 32'(set_reg);
    assign set_addr = set_ext[SET_AW-1:0];

    assign item_ctl.cmd    = cmd_reg;
    assign item_ctl.hit    = hit_reg;
    assign item_ctl.set_ok = set_ext < NUM_SETS;
    assign item_ctl.way_ok = 32'(way_reg) < NUM_WAYS;

    // Hash PC straight off the port on acceptance
    ssr_sig_unit #(
        .SIG_ENTRIES (SIG_ENTRIES)
    ) u_sig (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .pc        (req.pc),
        .sig_valid (sig_valid),
        .sig       (sig)
    );

    ssr_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_rrpv_ram (
        .clk   (clk),
        .we    (rrpv_we),
        .waddr (rrpv_waddr),
        .wdata (rrpv_wdata),
        .re    (rrpv_re),
        .raddr (rrpv_raddr),
        .rdata (rrpv_rdata)
    );

    ssr_ram #(
        .WIDTH (2),
        .DEPTH (SIG_ENTRIES)
    ) u_ctr_ram (
        .clk   (clk),
        .we    (ctr_we),
        .waddr (ctr_waddr),
        .wdata (ctr_wdata),
        .re    (ctr_re),
        .raddr (sig),
        .rdata (ctr_rdata)
    );

    ssr_row_upd #(
        .NUM_WAYS (NUM_WAYS)
    ) u_upd (
        .row        (rrpv_rdata),
        .ctr        (ctr_rdata),
        .ctl        (item_ctl),
        .way_index  (way_reg),
        .new_row    (new_row),
        .new_ctr    (new_ctr),
        .victim_way (victim_way),
        .upd        (upd)
    );

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        req_ready  = 1'b0;
        exec_fire  = 1'b0;
        rrpv_re    = 1'b0;
        ctr_re     = 1'b0;
        rrpv_we    = 1'b0;
        ctr_we     = 1'b0;
        rrpv_raddr = set_addr;
        rrpv_waddr = set_addr;
        rrpv_wdata = new_row;
        ctr_waddr  = sig;
        ctr_wdata  = new_ctr;

        unique case (state_reg)
            ssr_pkg::ST_CLEAR:
            begin
                // sweep both memories back to their reset contents
                rrpv_we    = clr_ext < NUM_SETS;
                ctr_we     = clr_ext < SIG_ENTRIES;
                rrpv_waddr = clr_ext[SET_AW-1:0];
                ctr_waddr  = clr_ext[SIG_AW-1:0];
                rrpv_wdata = {ROW_W{1'b1}};
                ctr_wdata  = ssr_pkg::CTR_INIT;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ssr_pkg::ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ssr_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req.valid)
                begin
                    state_next = ssr_pkg::ST_HASH;
                end
            end
            ssr_pkg::ST_HASH:
            begin
                // issue both reads once the signature is ready
                if (sig_valid)
                begin
                    rrpv_re    = 1'b1;
                    ctr_re     = 1'b1;
                    state_next = ssr_pkg::ST_EXEC;
                end
            end
            ssr_pkg::ST_EXEC:
            begin
                // hold the read data until the result register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    exec_fire  = 1'b1;
                    rrpv_we    = upd.row_we;
                    ctr_we     = upd.ctr_we;
                    state_next = ssr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssr_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssr_pkg::ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.cmd;
            set_reg <= req.set_index;
            way_reg <= req.way_index;
            hit_reg <= req.hit;
        end
        if (exec_fire)
        begin
            victim_reg <= victim_way;
            reuse_reg  <= upd.reuse;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.victim_way      = victim_reg;
    assign rsp.reuse_predicted = reuse_reg;

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ssr_pkg::ST_EXEC))
        else $error("result raised outside write-back");

    a_sig_only_when_hashing: assert property (@(posedge clk) disable iff (!rst_n)
        sig_valid |-> (state_reg == ssr_pkg::ST_HASH))
        else $error("signature arrived with no item in flight");

    a_accept_starts_hash: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ssr_pkg::ST_HASH) && !req_ready)
        else $error("accepted item did not enter the hash pipeline");

endmodule

`default_nettype wire

FILE: sv/ssr_ram.sv
`default_nettype none

module ssr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/ssr_sig_unit.sv
`default_nettype none

// Signature hash and reduction modulo SIG_ENTRIES by reciprocal multiplication.
module ssr_sig_unit #(
    parameter int SIG_ENTRIES = 1024,
    parameter int SIG_AW      = $clog2(SIG_ENTRIES)
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [ssr_pkg::PC_W-1:0] pc,
    output logic                         sig_valid,
    output logic      [SIG_AW-1:0]       sig
);

    localparam int PW = ssr_pkg::PC_W;
    localparam logic [31:0]     SIG_RECIP = 32'((64'd1 << PW) / SIG_ENTRIES);
    localparam logic [PW-1:0]   MOD_W     = PW'(SIG_ENTRIES);
    localparam logic [SIG_AW:0] MOD_C     = (SIG_AW + 1)'(SIG_ENTRIES);

    logic                v1_reg, v2_reg, v3_reg;
    logic [PW-1:0]       hash;
    logic [PW+31:0]      prod1;
    logic [PW-1:0]       h1_reg, h1_next;
    logic [PW-1:0]       q1_reg, q1_next;
    logic [PW-1:0]       rem_full;
    logic [SIG_AW:0]     rem2_reg, rem2_next;
    logic [SIG_AW:0]     rem_fix;
    logic [SIG_AW-1:0]   sig3_reg, sig3_next;

    always_comb
    begin
        hash      = pc ^ (pc >> ssr_pkg::SIG_SHIFT_A) ^ (pc >> ssr_pkg::SIG_SHIFT_B);
        prod1     = (PW + 32)'(hash) * (PW + 32)'(SIG_RECIP);
        h1_next   = hash;
        // estimate is the true quotient or one below it
        q1_next   = prod1[2*PW-1:PW];
        rem_full  = h1_reg - (q1_reg * MOD_W);
        rem2_next = rem_full[SIG_AW:0];
        rem_fix   = (rem2_reg >= MOD_C) ? (rem2_reg - MOD_C) : rem2_reg;
        sig3_next = rem_fix[SIG_AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            h1_reg <= h1_next;
            q1_reg <= q1_next;
        end
        if (v1_reg)
        begin
            rem2_reg <= rem2_next;
        end
        if (v2_reg)
        begin
            sig3_reg <= sig3_next;
        end
    end

    assign sig_valid = v3_reg;
    assign sig       = sig3_reg;

    a_sig_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        sig_valid |-> (32'(sig) < SIG_ENTRIES))
        else $error("signature beyond table size");

endmodule

`default_nettype wire

FILE: sv/ssr_row_upd.sv
`default_nettype none

// Read-modify-write logic for one set row and one signature counter.
module ssr_row_upd #(
    parameter int NUM_WAYS = 16,
    parameter int WAY_W    = $clog2(NUM_WAYS)
) (
    input  wire logic [2*NUM_WAYS-1:0]  row,
    input  wire logic [1:0]             ctr,
    input  wire ssr_pkg::ssr_item_ctl_t ctl,
    input  wire logic [3:0]             way_index,
    output logic      [2*NUM_WAYS-1:0]  new_row,
    output logic      [1:0]             new_ctr,
    output logic      [3:0]             victim_way,
    output ssr_pkg::ssr_upd_ctl_t       upd
);

    logic [NUM_WAYS-1:0]   hi_vec, lo_vec, is_top;
    logic [1:0]            top, lift, newv;
    logic [2*NUM_WAYS-1:0] aged_row, repl_row;
    logic [WAY_W-1:0]      vic_idx;

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            hi_vec[w] = row[2*w+1];
            lo_vec[w] = row[2*w];
        end
        // largest RRPV in the set
        top[1] = |hi_vec;
        top[0] = top[1] ? |(hi_vec & lo_vec) : |lo_vec;
        lift   = ssr_pkg::RRPV_MAX - top;

        if (ctl.hit)
        begin
            newv = ssr_pkg::RRPV_HIT;
        end
        else if (ctr[1])
        begin
            newv = ssr_pkg::RRPV_INSERT;
        end
        else
        begin
            newv = ssr_pkg::RRPV_MAX;
        end

        for (int w = 0; w < NUM_WAYS; w++)
        begin
            aged_row[2*w +: 2] = row[2*w +: 2] + lift;
            is_top[w]          = (row[2*w +: 2] == top);
            repl_row[2*w +: 2] = (32'(way_index) == 32'(w)) ? newv : row[2*w +: 2];
        end

        // lowest way that reaches the maximum after ageing
        vic_idx = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (is_top[w])
            begin
                vic_idx = WAY_W'(w);
            end
        end

        if (ctl.hit)
        begin
            new_ctr = (ctr == ssr_pkg::CTR_MAX) ? ctr : ctr + 2'd1;
        end
        else
        begin
            new_ctr = (ctr == ssr_pkg::CTR_MIN) ? ctr : ctr - 2'd1;
        end

        unique case (ctl.cmd)
            ssr_pkg::CMD_VICTIM:
            begin
                new_row    = aged_row;
                victim_way = ctl.set_ok ? 4'(vic_idx) : 4'd0;
                upd.row_we = ctl.set_ok;
                upd.ctr_we = 1'b0;
                upd.reuse  = 1'b0;
            end
            ssr_pkg::CMD_UPDATE:
            begin
                new_row    = repl_row;
                victim_way = 4'd0;
                upd.row_we = ctl.set_ok && ctl.way_ok;
                upd.ctr_we = 1'b1;
                upd.reuse  = !ctl.hit && ctr[1];
            end
            default:
            begin
                new_row    = row;
                victim_way = 4'd0;
                upd        = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ssr_pkg::*;

    // Geometry of the block as instantiated below (defaults)
    localparam int NUM_SETS    = 2048;
    localparam int NUM_WAYS    = 16;
    localparam int SIG_ENTRIES = 1024;

    // Run shape
    localparam int N_DIRECTED   = 16;
    localparam int RANDOM_ITEMS = 1400;
    localparam int QUIET_TAIL   = 150;     // final items sent with no idling on either side
    localparam int DRAIN_CYCLES = 12;      // extra tail after the owed results drain
    localparam int CYCLE_LIMIT  = 400000;  // clearing pass plus worst-case gaps, several times over

    // A miss fill predicts reuse when the signature counter is at least this
    localparam logic [1:0] REUSE_THRESH = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [10:0] set_index;
        logic [3:0]  way_index;
        logic [29:0] pc;
        logic        hit;
    } access_t;

    typedef struct packed {
        logic [3:0] victim_way;
        logic       reuse_predicted;
    } outcome_t;

    // One row of the directed table: the access, and a typed-in outcome where
    // 'typed' is set; otherwise the outcome comes from the predictor.
    typedef struct packed {
        access_t  acc;
        logic     typed;
        outcome_t outc;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    ssr_req_if req_ch ();
    ssr_rsp_if rsp_ch ();

    ship_srrip_replacement_top #(
        .NUM_SETS    (NUM_SETS),
        .NUM_WAYS    (NUM_WAYS),
        .SIG_ENTRIES (SIG_ENTRIES)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #1 clk = ~clk;

    // Shadow copy of the replacement state: one 2-bit RRPV per way per set,
    // and one 2-bit saturating counter per PC signature.
    logic [1:0] rrpv_tbl [NUM_SETS][NUM_WAYS];
    logic [1:0] sig_ctr  [SIG_ENTRIES];

    // Outcomes still owed by the block, oldest first
    outcome_t   outcome_q [$];
    outcome_t   due_outcome;

    dir_row_t   directed_rows [N_DIRECTED];
    logic [10:0] hot_sets [4];
    logic [29:0] hot_pcs  [8];

    int unsigned cycles;
    int unsigned failures;
    int unsigned sent;
    int unsigned checked;
    int unsigned victims;
    int unsigned aged_sets;
    int unsigned reuse_fills;
    int unsigned req_idle_pct;
    int unsigned rsp_idle_pct;
    logic [3:0]  last_victim;

    // Work out the outcome of one access and advance the shadow state.
    task predict_access(input access_t a, output outcome_t o);
        logic [29:0] h;
        logic [9:0]  sig;
        logic [1:0]  top;
        logic [1:0]  lift;
        logic [1:0]  ctr;
        logic [1:0]  ins;
        bit          found;
        o = '0;
        if (a.cmd == CMD_VICTIM)
        begin
            // Age the whole set so that its largest RRPV reaches the maximum
            top = 2'd0;
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                if (rrpv_tbl[a.set_index][w] > top)
                    top = rrpv_tbl[a.set_index][w];
            end
            lift = RRPV_MAX - top;
            if (lift != 2'd0)
            begin
                aged_sets++;
                for (int w = 0; w < NUM_WAYS; w++)
                    rrpv_tbl[a.set_index][w] = rrpv_tbl[a.set_index][w] + lift;
            end
            // Lowest-numbered way at the maximum wins
            found = 1'b0;
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                if (!found && rrpv_tbl[a.set_index][w] == RRPV_MAX)
                begin
                    o.victim_way = 4'(w);
                    found = 1'b1;
                end
            end
            victims++;
        end
        else
        begin
            h   = a.pc ^ (a.pc >> SIG_SHIFT_A) ^ (a.pc >> SIG_SHIFT_B);
            sig = h[9:0];
            ctr = sig_ctr[sig];
            if (a.hit)
            begin
                ins = RRPV_HIT;
                if (ctr != CTR_MAX)
                    ctr = ctr + 2'd1;
            end
            else
            begin
                if (ctr >= REUSE_THRESH)
                begin
                    o.reuse_predicted = 1'b1;
                    ins = RRPV_INSERT;
                    reuse_fills++;
                end
                else
                    ins = RRPV_MAX;
                if (ctr != CTR_MIN)
                    ctr = ctr - 2'd1;
            end
            sig_ctr[sig] = ctr;
            rrpv_tbl[a.set_index][a.way_index] = ins;
        end
    endtask

    // Present one item, hold it until the block takes it, then log the outcome
    // owed. Optionally drop valid for a burst afterwards.
    task automatic send_access(input access_t a, input logic typed, input outcome_t typed_out);
        outcome_t o;
        req_ch.valid     <= 1'b1;
        req_ch.cmd       <= a.cmd;
        req_ch.set_index <= a.set_index;
        req_ch.way_index <= a.way_index;
        req_ch.pc        <= a.pc;
        req_ch.hit       <= a.hit;
        forever
        begin
            @(posedge clk);
            if (req_ch.ready)
                break;
        end
        predict_access(a, o);
        outcome_q.push_back(typed ? typed_out : o);
        last_victim = o.victim_way;
        sent++;
        // Idle burst on the request side; valid stays high otherwise, so a
        // back-to-back item never sees valid lowered and raised in one step
        if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // Access to one of the hot sets with one of the hot PCs, so that rows
    // fill up, age and counters saturate in both directions.
    function automatic access_t hot_access(input logic cmd);
        access_t a;
        a.cmd       = cmd;
        a.set_index = hot_sets[$urandom_range(0, 3)];
        a.way_index = 4'($urandom_range(0, NUM_WAYS - 1));
        a.pc        = hot_pcs[$urandom_range(0, 7)];
        a.hit       = 1'($urandom_range(0, 1));
        return a;
    endfunction

    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    // Response side: hold ready high, drop it in bursts at the current rate.
    initial
    begin
        rsp_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest owed outcome.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid && rsp_ch.ready)
        begin
            if (outcome_q.size() == 0)
            begin
                $error("unexpected result: victim_way %0d reuse_predicted %0d",
                       rsp_ch.victim_way, rsp_ch.reuse_predicted);
                failures++;
            end
            else
            begin
                due_outcome = outcome_q.pop_front();
                if (rsp_ch.victim_way !== due_outcome.victim_way)
                begin
                    $error("victim_way mismatch: expected %0d, actual %0d",
                           due_outcome.victim_way, rsp_ch.victim_way);
                    failures++;
                end
                if (rsp_ch.reuse_predicted !== due_outcome.reuse_predicted)
                begin
                    $error("reuse_predicted mismatch: expected %0d, actual %0d",
                           due_outcome.reuse_predicted, rsp_ch.reuse_predicted);
                    failures++;
                end
                checked++;
            end
        end
    end

    // Watchdog: give up if the run stalls.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("ship_srrip_replacement_top test failed");
            $finish;
        end
    end

    initial
    begin
        access_t     a;
        int unsigned kind;
        int unsigned phase;
        int unsigned hit_pct;
        int unsigned total;

        cycles       = 0;
        failures     = 0;
        sent         = 0;
        checked      = 0;
        victims      = 0;
        aged_sets    = 0;
        reuse_fills  = 0;
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        last_victim  = '0;
        phase        = 0;
        total        = N_DIRECTED + RANDOM_ITEMS;

        // Shadow state after reset: every RRPV at maximum, counters at init
        for (int s = 0; s < NUM_SETS; s++)
            for (int w = 0; w < NUM_WAYS; w++)
                rrpv_tbl[s][w] = RRPV_MAX;
        for (int i = 0; i < SIG_ENTRIES; i++)
            sig_ctr[i] = CTR_INIT;

        // Drive every input to a known value from time zero
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.cmd       <= CMD_VICTIM;
        req_ch.set_index <= '0;
        req_ch.way_index <= '0;
        req_ch.pc        <= '0;
        req_ch.hit       <= 1'b0;

        // Directed table. Typed outcomes follow straight from the reset state:
        //  - empty sets pick way 0; a hit way drops out, so the next way wins
        //  - pc all-ones hashes to signature 3FF; counter walks 2 -> 1 -> 0 and
        //    stays at 0, inserting at 2 only on the first miss
        //  - pc 0 hashes to signature 0; after the earlier hit it saturates at 3
        //    and a miss then predicts reuse
        //  - the remaining rows, with other sets, ways and PCs, are left to the predictor
        directed_rows = '{
            '{'{CMD_VICTIM, 11'd0,    4'd0,  30'h00000000, 1'b0}, 1'b1, '{4'd0, 1'b0}},
            '{'{CMD_VICTIM, 11'd2047, 4'd15, 30'h3FFFFFFF, 1'b1}, 1'b1, '{4'd0, 1'b0}},
            '{'{CMD_UPDATE, 11'd0,    4'd0,  30'h00000000, 1'b1}, 1'b1, '{4'd0, 1'b0}},
            '{'{CMD_VICTIM, 11'd0,    4'd0,  30'h00000000, 1'b0}, 1'b1, '{4'd1, 1'b0}},
            '{'{CMD_UPDATE, 11'd0,    4'd15, 30'h3FFFFFFF, 1'b0}, 1'b1, '{4'd0, 1'b1}},
            '{'{CMD_UPDATE, 11'd2047, 4'd0,  30'h3FFFFFFF, 1'b0}, 1'b1, '{4'd0, 1'b0}},
            '{'{CMD_UPDATE, 11'd2047, 4'd1,  30'h3FFFFFFF, 1'b0}, 1'b1, '{4'd0, 1'b0}},
            '{'{CMD_UPDATE, 11'd2047, 4'd15, 30'h00000000, 1'b1}, 1'b1, '{4'd0, 1'b0}},
            '{'{CMD_UPDATE, 11'd2047, 4'd7,  30'h00000000, 1'b0}, 1'b1, '{4'd0, 1'b1}},
            '{'{CMD_VICTIM, 11'd2047, 4'd0,  30'h00000000, 1'b0}, 1'b1, '{4'd0, 1'b0}},
            '{'{CMD_UPDATE, 11'd1365, 4'd10, 30'h2AAAAAAA, 1'b1}, 1'b0, '{4'd0, 1'b0}},
            '{'{CMD_UPDATE, 11'd682,  4'd5,  30'h15555555, 1'b0}, 1'b0, '{4'd0, 1'b0}},
            '{'{CMD_UPDATE, 11'd1,    4'd0,  30'h00001001, 1'b1}, 1'b0, '{4'd0, 1'b0}},
            '{'{CMD_UPDATE, 11'd1,    4'd1,  30'h00100000, 1'b0}, 1'b0, '{4'd0, 1'b0}},
            '{'{CMD_VICTIM, 11'd1,    4'd9,  30'h12345678, 1'b1}, 1'b0, '{4'd0, 1'b0}},
            '{'{CMD_VICTIM, 11'd1365, 4'd3,  30'h0ABCDEF0, 1'b0}, 1'b0, '{4'd0, 1'b0}}
        };

        // Hot pools: extremes plus random picks
        hot_sets[0] = 11'd0;
        hot_sets[1] = 11'd2047;
        hot_sets[2] = 11'($urandom_range(1, 2046));
        hot_sets[3] = 11'($urandom_range(1, 2046));
        hot_pcs[0]  = 30'h00000000;
        hot_pcs[1]  = 30'h3FFFFFFF;
        for (int i = 2; i < 8; i++)
            hot_pcs[i] = 30'($urandom);

        // Hold reset, then release it once for good
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table; ready stays low through the clearing pass
        for (int i = 0; i < N_DIRECTED; i++)
            send_access(directed_rows[i].acc, directed_rows[i].typed, directed_rows[i].outc);

        while (sent < total)
        begin
            // Change idling rates every 128 items; silence both sides at the end
            if (sent >= total - QUIET_TAIL)
            begin
                req_idle_pct = 0;
                rsp_idle_pct = 0;
            end
            else if (sent / 128 != phase)
            begin
                phase        = sent / 128;
                req_idle_pct = pick_idle_pct();
                rsp_idle_pct = pick_idle_pct();
            end

            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                // Single access to a hot set, victim or update
                a = hot_access(($urandom_range(0, 99) < 30) ? CMD_VICTIM : CMD_UPDATE);
                send_access(a, 1'b0, '0);
            end
            else if (kind < 60)
            begin
                // Cache miss flow: choose a victim, then fill that way
                a = hot_access(CMD_VICTIM);
                send_access(a, 1'b0, '0);
                a.cmd       = CMD_UPDATE;
                a.way_index = last_victim;
                a.pc        = hot_pcs[$urandom_range(0, 7)];
                a.hit       = 1'b0;
                send_access(a, 1'b0, '0);
            end
            else if (kind < 80)
            begin
                // Sweep every way of one set, then ask for a victim; all-hit
                // sweeps force the largest ageing step, all-miss ones a small one
                case ($urandom_range(0, 2))
                    0: hit_pct = 0;
                    1: hit_pct = 50;
                    default: hit_pct = 100;
                endcase
                a = hot_access(CMD_UPDATE);
                for (int w = 0; w < NUM_WAYS; w++)
                begin
                    a.way_index = 4'(w);
                    a.pc        = hot_pcs[$urandom_range(0, 7)];
                    a.hit       = ($urandom_range(0, 99) < hit_pct);
                    send_access(a, 1'b0, '0);
                end
                a.cmd = CMD_VICTIM;
                send_access(a, 1'b0, '0);
            end
            else
            begin
                // Noise: every field drawn across its whole range
                a.cmd       = 1'($urandom_range(0, 1));
                a.set_index = 11'($urandom_range(0, NUM_SETS - 1));
                a.way_index = 4'($urandom_range(0, NUM_WAYS - 1));
                a.pc        = 30'($urandom);
                a.hit       = 1'($urandom_range(0, 1));
                send_access(a, 1'b0, '0);
            end
        end

        // Drop valid, let the owed results drain, then allow a short tail
        req_ch.valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items: %0d victim selections (%0d with set ageing), %0d miss fills",
                 sent, victims, aged_sets, reuse_fills);
        $display("predicting reuse; %0d results compared, %0d mismatches", checked, failures);
        if (failures == 0 && outcome_q.size() == 0)
            $display("ship_srrip_replacement_top test passed");
        else
            $display("ship_srrip_replacement_top test failed");
        $finish;
    end

endmodule
